FILE: src/i2cra_pkg.sv
`timescale 1ns / 1ps
// Package for the I2C single-register access master.
// Holds request codes, engine step codes, status codes and shared types; no dependencies.
package i2cra_pkg;

    // Operation codes on the request channel.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Classified request kinds, as they travel through the queue.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Sequencer steps of the bus engine.
    localparam logic [3:0] STEP_IDLE      = 4'd0;
    localparam logic [3:0] STEP_START     = 4'd1;
    localparam logic [3:0] STEP_SEND_DEV  = 4'd2;
    localparam logic [3:0] STEP_ACK_DEV   = 4'd3;
    localparam logic [3:0] STEP_SEND_REG  = 4'd4;
    localparam logic [3:0] STEP_ACK_REG   = 4'd5;
    localparam logic [3:0] STEP_RESTART   = 4'd6;
    localparam logic [3:0] STEP_SEND_RD   = 4'd7;
    localparam logic [3:0] STEP_ACK_RD    = 4'd8;
    localparam logic [3:0] STEP_RECV      = 4'd9;
    localparam logic [3:0] STEP_NOACK     = 4'd10;
    localparam logic [3:0] STEP_SEND_DATA = 4'd11;
    localparam logic [3:0] STEP_ACK_DATA  = 4'd12;
    localparam logic [3:0] STEP_STOP      = 4'd13;

    // Transaction status codes.
    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_START_FAIL = 3'd1;
    localparam logic [2:0] STATUS_DEV_NACK   = 3'd2;
    localparam logic [2:0] STATUS_REG_NACK   = 3'd3;
    localparam logic [2:0] STATUS_DATA_NACK  = 3'd4;

    // Reset value of the phase length register.
    localparam logic [7:0] PHASE_TICKS_RESET = 8'd5;

    // Number of bits in one bus byte.
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // One classified request as held in the queue.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       sda_in;
    } t_cmd;

    // Line drive levels together with the transmit shift byte.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] shift;
    } t_lines;

endpackage

FILE: src/i2cra_req_if.sv
`timescale 1ns / 1ps
// Request channel interface: valid/ready handshake plus one tick's request fields.
// No dependencies.
interface i2cra_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (
        output valid, operation, device_address, register_address, write_data, sda_in,
        input  ready
    );
    modport sink (
        input  valid, operation, device_address, register_address, write_data, sda_in,
        output ready
    );
endinterface

FILE: src/i2cra_res_if.sv
`timescale 1ns / 1ps
// Result channel interface: valid/ready handshake plus the bus drive and status fields.
// No dependencies.
interface i2cra_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] read_data;

    modport source (
        output valid, scl_out, sda_out, busy_res, done_res, status, read_data,
        input  ready
    );
    modport sink (
        input  valid, scl_out, sda_out, busy_res, done_res, status, read_data,
        output ready
    );
endinterface

FILE: src/i2cra_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests and classifies the operation code into a queue entry.
// Depends on i2cra_pkg and i2cra_req_if.
module i2cra_front (
    i2cra_req_if.sink      i_req,
    input  logic           i_queue_full,
    output logic           o_push,
    output i2cra_pkg::t_cmd o_cmd
);
    import i2cra_pkg::*;

    logic [1:0] kind;

    // Decode the operation; the unused code behaves as a plain tick.
    always_comb begin
        case (i_req.operation)
            OP_READ:  kind = KIND_READ;
            OP_WRITE: kind = KIND_WRITE;
            default:  kind = KIND_TICK;
        endcase
    end

    // A request is taken whenever the queue has room.
    assign i_req.ready = !i_queue_full;
    assign o_push      = i_req.valid && !i_queue_full;

    assign o_cmd.kind             = kind;
    assign o_cmd.device_address   = i_req.device_address;
    assign o_cmd.register_address = i_req.register_address;
    assign o_cmd.write_data       = i_req.write_data;
    assign o_cmd.sda_in           = i_req.sda_in;
endmodule

FILE: src/i2cra_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue of classified requests between front end and engine.
// Depends on i2cra_pkg.
module i2cra_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  i2cra_pkg::t_cmd i_push_data,
    output logic            o_full,
    output logic            o_valid,
    output i2cra_pkg::t_cmd o_data,
    input  logic            i_pop
);
    import i2cra_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage is written at the write pointer; no reset needed on payload.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

FILE: src/i2cra_engine.sv
`timescale 1ns / 1ps
// Back end: the bus sequencer, advancing one tick per popped request, with an output register.
// Depends on i2cra_pkg and i2cra_res_if.
module i2cra_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_phase_ticks,
    input  logic            i_cmd_valid,
    input  i2cra_pkg::t_cmd i_cmd,
    output logic            o_pop,
    i2cra_res_if.source     o_res
);
    import i2cra_pkg::*;

    // Line levels and shift byte on entry to a step and phase.
    function automatic t_lines f_enter(input logic [3:0] step, input logic [1:0] sub,
                                       input t_lines cur);
        t_lines nx;
        nx = cur;
        case (step)
            STEP_START, STEP_RESTART: begin
                nx.scl = 1'b1;
                nx.sda = (sub == 2'd0);
            end
            STEP_SEND_DEV, STEP_SEND_REG, STEP_SEND_RD, STEP_SEND_DATA: begin
                if (sub == 2'd0) begin
                    nx.scl = 1'b0;
                end else if (sub == 2'd1) begin
                    nx.scl   = 1'b0;
                    nx.sda   = cur.shift[7];
                    nx.shift = {cur.shift[6:0], 1'b0};
                end else begin
                    nx.scl = 1'b1;
                end
            end
            STEP_ACK_DEV, STEP_ACK_REG, STEP_ACK_RD, STEP_ACK_DATA: begin
                if (sub == 2'd0) begin
                    nx.scl = 1'b0;
                end else begin
                    nx.scl = (sub != 2'd1);
                    nx.sda = 1'b1;
                end
            end
            STEP_RECV: begin
                nx.sda = 1'b1;
                nx.scl = (sub != 2'd0);
            end
            STEP_NOACK: begin
                if (sub == 2'd1) begin
                    nx.sda = 1'b1;
                end
                nx.scl = (sub == 2'd2);
            end
            STEP_STOP: begin
                nx.scl = (sub >= 2'd2);
                if (sub == 2'd1 || sub == 2'd2) begin
                    nx.sda = 1'b0;
                end else if (sub == 2'd3) begin
                    nx.sda = 1'b1;
                end
            end
            default: begin
                nx = cur;
            end
        endcase
        return nx;
    endfunction

    // Sequencer state.
    logic [7:0] r_timer, n_timer;
    logic [3:0] r_step, n_step;
    logic [1:0] r_sub, n_sub;
    logic [3:0] r_bits, n_bits;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_dev, n_dev;
    logic [7:0] r_reg, n_reg;
    logic [7:0] r_data, n_data;
    logic       r_is_write, n_is_write;
    logic [2:0] r_status, n_status;
    logic [7:0] r_rx, n_rx;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;

    // Output register.
    logic       r_out_valid;
    logic       r_out_scl;
    logic       r_out_sda;
    logic       r_out_busy;
    logic       r_out_done;
    logic [2:0] r_out_status;
    logic [7:0] r_out_rx;

    logic       advance;
    logic       done;
    logic       en;
    logic [3:0] en_step;
    logic [1:0] en_sub;
    logic [7:0] ticks_eff;
    logic [7:0] t_left;
    logic [3:0] bits_inc;
    logic [7:0] rx_shift;
    logic       s;
    logic       fail;
    logic       restart;
    t_lines     lines;

    // A request is processed when the output register is free or being drained.
    assign advance   = i_cmd_valid && (!r_out_valid || o_res.ready);
    assign o_pop     = advance;
    assign ticks_eff = (i_phase_ticks == 8'd0) ? 8'd1 : i_phase_ticks;
    assign s         = i_cmd.sda_in;
    assign t_left    = (r_timer != 8'd0) ? r_timer - 8'd1 : 8'd0;
    assign bits_inc  = r_bits + 4'd1;
    assign rx_shift  = {r_shift[6:0], s};
    assign fail      = (r_sub == 2'd0 && !s) || (r_sub == 2'd1 && s);
    assign restart   = (r_step == STEP_RESTART);

    // Next state for one tick.
    always_comb begin
        n_timer    = r_timer;
        n_step     = r_step;
        n_sub      = r_sub;
        n_bits     = r_bits;
        n_shift    = r_shift;
        n_dev      = r_dev;
        n_reg      = r_reg;
        n_data     = r_data;
        n_is_write = r_is_write;
        n_status   = r_status;
        n_rx       = r_rx;
        n_scl      = r_scl;
        n_sda      = r_sda;
        done       = 1'b0;
        en         = 1'b0;
        en_step    = r_step;
        en_sub     = 2'd0;
        lines      = '0;

        if (r_step == STEP_IDLE) begin
            // Idle: a read or write request latches its operands and starts.
            if (i_cmd.kind == KIND_READ || i_cmd.kind == KIND_WRITE) begin
                n_dev      = i_cmd.device_address;
                n_reg      = i_cmd.register_address;
                n_data     = i_cmd.write_data;
                n_is_write = (i_cmd.kind == KIND_WRITE);
                n_bits     = 4'd0;
                en         = 1'b1;
                en_step    = STEP_START;
                en_sub     = 2'd0;
            end
        end else begin
            n_timer = t_left;
            if (t_left == 8'd0) begin
                // End of a phase: pick the next phase or step.
                case (r_step)
                    STEP_START, STEP_RESTART: begin
                        if (r_sub < 2'd2 && !fail) begin
                            en      = 1'b1;
                            en_step = r_step;
                            en_sub  = r_sub + 2'd1;
                        end else if (fail && !restart) begin
                            n_status = STATUS_START_FAIL;
                            done     = 1'b1;
                        end else begin
                            n_bits = 4'd0;
                            en     = 1'b1;
                            en_sub = 2'd0;
                            if (restart) begin
                                n_shift = {r_dev[7:1], 1'b1};
                                en_step = STEP_SEND_RD;
                            end else begin
                                n_shift = {r_dev[7:1], 1'b0};
                                en_step = STEP_SEND_DEV;
                            end
                        end
                    end
                    STEP_SEND_DEV, STEP_SEND_REG, STEP_SEND_RD, STEP_SEND_DATA: begin
                        en = 1'b1;
                        if (r_sub < 2'd2) begin
                            en_step = r_step;
                            en_sub  = r_sub + 2'd1;
                        end else begin
                            n_bits  = bits_inc;
                            en_step = (bits_inc < BYTE_BITS) ? r_step : r_step + 4'd1;
                            en_sub  = 2'd0;
                        end
                    end
                    STEP_ACK_DEV, STEP_ACK_REG, STEP_ACK_RD, STEP_ACK_DATA: begin
                        en = 1'b1;
                        if (r_sub < 2'd2) begin
                            en_step = r_step;
                            en_sub  = r_sub + 2'd1;
                        end else if (r_step == STEP_ACK_DEV) begin
                            if (s) begin
                                n_status = STATUS_DEV_NACK;
                                en_step  = STEP_STOP;
                            end else begin
                                n_shift = r_reg;
                                n_bits  = 4'd0;
                                en_step = STEP_SEND_REG;
                            end
                        end else if (r_step == STEP_ACK_REG) begin
                            if (!r_is_write) begin
                                en_step = STEP_RESTART;
                            end else if (s) begin
                                n_status = STATUS_REG_NACK;
                                en_step  = STEP_STOP;
                            end else begin
                                n_shift = r_data;
                                n_bits  = 4'd0;
                                en_step = STEP_SEND_DATA;
                            end
                        end else if (r_step == STEP_ACK_RD) begin
                            n_shift = 8'd0;
                            n_bits  = 4'd0;
                            en_step = STEP_RECV;
                        end else begin
                            n_status = s ? STATUS_DATA_NACK : STATUS_OK;
                            en_step  = STEP_STOP;
                        end
                    end
                    STEP_RECV: begin
                        en      = 1'b1;
                        en_step = STEP_RECV;
                        if (r_sub == 2'd0) begin
                            en_sub = 2'd1;
                        end else begin
                            n_shift = rx_shift;
                            n_bits  = bits_inc;
                            if (bits_inc >= BYTE_BITS) begin
                                n_rx     = rx_shift;
                                n_status = STATUS_OK;
                                en_step  = STEP_NOACK;
                            end
                        end
                    end
                    STEP_NOACK: begin
                        en = 1'b1;
                        if (r_sub < 2'd3) begin
                            en_step = STEP_NOACK;
                            en_sub  = r_sub + 2'd1;
                        end else begin
                            en_step = STEP_STOP;
                        end
                    end
                    STEP_STOP: begin
                        if (r_sub < 2'd3) begin
                            en      = 1'b1;
                            en_step = STEP_STOP;
                            en_sub  = r_sub + 2'd1;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
        end

        // Entering a phase sets the lines and reloads the phase timer.
        if (en) begin
            lines   = f_enter(en_step, en_sub, '{scl: n_scl, sda: n_sda, shift: n_shift});
            n_step  = en_step;
            n_sub   = en_sub;
            n_scl   = lines.scl;
            n_sda   = lines.sda;
            n_shift = lines.shift;
            n_timer = ticks_eff;
        end

        // Closing a transaction returns to idle.
        if (done) begin
            n_step  = STEP_IDLE;
            n_sub   = 2'd0;
            n_timer = 8'd0;
        end
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer    <= 8'd0;
            r_step     <= STEP_IDLE;
            r_sub      <= 2'd0;
            r_bits     <= 4'd0;
            r_shift    <= 8'd0;
            r_dev      <= 8'd0;
            r_reg      <= 8'd0;
            r_data     <= 8'd0;
            r_is_write <= 1'b0;
            r_status   <= STATUS_OK;
            r_rx       <= 8'd0;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
        end else if (advance) begin
            r_timer    <= n_timer;
            r_step     <= n_step;
            r_sub      <= n_sub;
            r_bits     <= n_bits;
            r_shift    <= n_shift;
            r_dev      <= n_dev;
            r_reg      <= n_reg;
            r_data     <= n_data;
            r_is_write <= n_is_write;
            r_status   <= n_status;
            r_rx       <= n_rx;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_scl    <= n_scl;
            r_out_sda    <= n_sda;
            r_out_busy   <= (n_step != STEP_IDLE);
            r_out_done   <= done;
            r_out_status <= n_status;
            r_out_rx     <= n_rx;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_out   = r_out_scl;
    assign o_res.sda_out   = r_out_sda;
    assign o_res.busy_res  = r_out_busy;
    assign o_res.done_res  = r_out_done;
    assign o_res.status    = r_out_status;
    assign o_res.read_data = r_out_rx;
endmodule

FILE: src/i2c_master_register_access.sv
`timescale 1ns / 1ps
// Top level of the I2C single-register read/write master.
// Depends on i2cra_pkg, the channel interfaces, i2cra_front, i2cra_queue and i2cra_engine.

// Each request is one bit-timing tick: it carries the sampled SDA level and, while the
// master is idle, an optional register read or write with its addresses and data. Every
// request gives exactly one result with the SCL/SDA drive levels, busy and done flags,
// the status code and the last byte read. The block takes one tick per clock cycle while
// results are accepted; the bus sequencer updates its state once per tick. A request
// waits in the request queue and its result in the output register. The queue of
// QUEUE_DEPTH entries keeps taking requests while results are held up, until it is full.
// Each bus phase lasts phase_ticks ticks (zero acts as one); write the phase length only
// while no transaction runs.
module i2c_master_register_access #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    i2cra_req_if.sink   i_req,
    i2cra_res_if.source o_res
);
    import i2cra_pkg::*;

    logic [7:0] r_phase_ticks;
    logic       push;
    logic       queue_full;
    t_cmd       push_cmd;
    logic       cmd_valid;
    t_cmd       cmd;
    logic       pop;

    // Phase length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_wdata;
        end
    end

    // Request intake and classification.
    i2cra_front u_front (
        .i_req        (i_req),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Queue between intake and the bus engine.
    i2cra_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (queue_full),
        .o_valid     (cmd_valid),
        .o_data      (cmd),
        .i_pop       (pop)
    );

    // Bus sequencer and result register.
    i2cra_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_ticks (r_phase_ticks),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_pop         (pop),
        .o_res         (o_res)
    );
endmodule
